// ----- hdl/svtb_pkg.sv -----
package svtb_pkg;

    // grid and table geometry (64-voxel edge, three levels)
    localparam int VOX_AW        = 18;
    localparam int VOX_DEPTH     = 262144;
    localparam int BRICK_AW      = 12;
    localparam int BRICK_DEPTH   = 4096;
    localparam int MID_AW        = 6;
    localparam int MID_DEPTH     = 64;
    localparam int NODE_AW       = 13;
    localparam int NODE_DEPTH    = 4161;
    localparam int MAX_LEVELS    = 3;
    localparam int LEAF_FLAG_POS = 31;

    // command codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_WRITE     = 2'd0,
        OP_BUILD     = 2'd1,
        OP_READ_NODE = 2'd2,
        OP_READ_MAT  = 2'd3
    } op_t;

    // occupancy state of a tree node
    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_FULL  = 2'd1,
        ST_MIXED = 2'd2
    } occ_state_t;

    // build sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_BRICK,
        S_BRICK_DR,
        S_LEVEL,
        S_LEVEL_DR,
        S_F_INIT,
        S_F_RD,
        S_F_LVL,
        S_F_NODE,
        S_F_SWEEP,
        S_F_DRAIN,
        S_F_ADV,
        S_DONE
    } fsm_t;

    // one result beat
    typedef struct packed {
        logic [18:0] material_total;
        logic [12:0] node_total;
        logic [15:0] leaf_material;
        logic [31:0] child_link;
        logic [63:0] node_mask;
        logic        index_valid;
    } result_t;

endpackage

// ----- hdl/svtb_out_stage.sv -----
module svtb_out_stage
    import svtb_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  result_t       res,
    output logic          room,
    output logic          m_tvalid,
    input  logic          m_tready,
    // node_mask, child_link, leaf_material, node_total, material_total
    output logic [143:0]  m_tdata,
    // index_valid
    output logic [0:0]    m_tuser
);

    logic    valid_reg;
    result_t data_reg;

    // output register frees when the beat is taken
    assign room = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.material_total, data_reg.node_total, data_reg.leaf_material,
                       data_reg.child_link, data_reg.node_mask};
    assign m_tuser  = data_reg.index_valid;

endmodule

// ----- hdl/sparse_voxel_tree_builder_top.sv -----
// voxel write: no result; one beat per cycle while idle and no read result is stalled
// node and material reads: same rate, result through the read and output registers
// build: the brick pass reads one voxel store entry a cycle, the upper levels read up to
// 4096 + 64 entries of the level below, then flattening does a 64-slot sweep per node
// reset clears the sequencer, counts and root; level_count resets to 3; stores are not cleared
module sparse_voxel_tree_builder_top
    import svtb_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // voxel_x, voxel_y, voxel_z, occupied, voxel_material, read_index
    input  logic [55:0]   s_tdata,
    // operation
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // node_mask, child_link, leaf_material, node_total, material_total
    output logic [143:0]  m_tdata,
    // index_valid
    output logic [0:0]    m_tuser,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_data
);

    localparam logic [31:0] LEAF_BIT = 32'd1 << LEAF_FLAG_POS;

    // voxel address of slot s in brick b
    function automatic logic [VOX_AW-1:0] vox_addr(input logic [11:0] b, input logic [5:0] s);
        vox_addr = {b[11:8], s[5:4], b[7:4], s[3:2], b[3:0], s[1:0]};
    endfunction

    // child index of slot s under parent p of level lvl
    function automatic logic [11:0] child_idx(input logic [1:0] lvl, input logic [5:0] p,
                                              input logic [5:0] s);
        child_idx = (lvl == 2'd1) ? {p[5:4], s[5:4], p[3:2], s[3:2], p[1:0], s[1:0]}
                                  : {6'd0, s};
    endfunction

    // lowest-corner voxel of an upper node
    function automatic logic [VOX_AW-1:0] corner(input logic [1:0] lvl, input logic [5:0] p);
        corner = (lvl == 2'd1) ? {p[5:4], 4'd0, p[3:2], 4'd0, p[1:0], 4'd0} : '0;
    endfunction

    function automatic occ_state_t mask_state(input logic [63:0] m);
        if (m == '0) begin
            mask_state = ST_EMPTY;
        end else if (&m) begin
            mask_state = ST_FULL;
        end else begin
            mask_state = ST_MIXED;
        end
    endfunction

    // input beat fields
    logic [5:0]  in_x, in_y, in_z;
    logic        in_occ;
    logic [15:0] in_mat;
    logic [17:0] in_ri;
    op_t         in_op;

    assign in_x   = s_tdata[5:0];
    assign in_y   = s_tdata[11:6];
    assign in_z   = s_tdata[17:12];
    assign in_occ = s_tdata[18];
    assign in_mat = s_tdata[34:19];
    assign in_ri  = s_tdata[52:35];
    assign in_op  = op_t'(s_tuser);

    // control registers
    fsm_t        state_reg, state_next;
    logic [1:0]  lc_reg;
    logic [12:0] nc_reg, nc_next;
    logic [18:0] mc_reg, mc_next;
    logic [17:0] cnt_reg, cnt_next;
    logic [1:0]  lvl_reg, lvl_next;
    logic        p_v_reg, p_v_next;
    logic [5:0]  p_slot_reg, p_slot_next;
    logic [11:0] p_idx_reg, p_idx_next;
    logic [63:0] acc_reg, acc_next;
    logic        empty_reg, empty_next, full_reg, full_next;
    logic [12:0] o_reg, o_next, end_reg, end_next;
    logic [11:0] cd_reg, cd_next;
    logic [63:0] cm_reg, cm_next;
    logic        leaf_reg, leaf_next;
    logic [65:0] root_reg, root_next;
    logic        pend_reg, pend_next, pend_ok_reg, pend_ok_next;
    op_t         pend_op_reg, pend_op_next;

    // memories
    logic [16:0] vox_mem [0:VOX_DEPTH-1];
    logic [65:0] brick_mem [0:BRICK_DEPTH-1];
    logic [65:0] mid_mem [0:MID_DEPTH-1];
    logic [11:0] dense_mem [0:NODE_DEPTH-1];
    logic [63:0] nmask_mem [0:NODE_DEPTH-1];
    logic [31:0] nlink_mem [0:NODE_DEPTH-1];
    logic [15:0] leaf_mem [0:VOX_DEPTH-1];

    logic              vox_we;
    logic [VOX_AW-1:0] vox_ra;
    logic [16:0]       vox_q;
    logic              brick_we, mid_we;
    logic [11:0]       lvl_ra;
    logic [65:0]       lvl_wd, brick_q, mid_q, lvl_q;
    logic [1:0]        sel_lvl;
    logic              dense_we;
    logic [NODE_AW-1:0] dense_wa;
    logic [11:0]       dense_wd, dense_q;
    logic              node_we, rd_node, rd_mat, leaf_we;
    logic [31:0]       nlink_wd;
    logic [63:0]       nmask_q;
    logic [31:0]       nlink_q;
    logic [15:0]       lmat_q, leaf_wd;

    // handshake and sequencing helpers
    logic        accept, out_room, move, pend_set, leaf_c;
    logic        brick_last, lvl_last, slot_last;
    logic [12:0] o_inc;
    occ_state_t  cs;
    result_t     res;

    assign cfg_ready  = 1'b1;
    assign s_tready   = (state_reg == S_IDLE) && (!pend_reg || out_room);
    assign accept     = s_tvalid && s_tready;
    assign move       = pend_reg && out_room;
    assign brick_last = &cnt_reg;
    assign lvl_last   = (lvl_reg == 2'd1) ? (&cnt_reg[11:0]) : (&cnt_reg[5:0]);
    assign slot_last  = &cnt_reg[5:0];
    assign o_inc      = o_reg + 13'd1;

    // level store data for the level being read
    assign sel_lvl = (state_reg == S_F_NODE) ? lvl_reg : lvl_reg - 2'd1;
    always_comb begin
        case (sel_lvl)
            2'd0:    lvl_q = brick_q;
            2'd1:    lvl_q = mid_q;
            default: lvl_q = root_reg;
        endcase
    end
    assign cs     = occ_state_t'(lvl_q[65:64]);
    assign leaf_c = (lvl_reg == 2'd0) || (cs == ST_FULL);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && in_op == OP_BUILD) begin
                    state_next = (lc_reg == 2'd0) ? S_DONE : S_BRICK;
                end
            end
            S_BRICK:    if (brick_last) state_next = S_BRICK_DR;
            S_BRICK_DR: state_next = (lc_reg >= 2'd2) ? S_LEVEL : S_F_INIT;
            S_LEVEL:    if (lvl_last) state_next = S_LEVEL_DR;
            S_LEVEL_DR: state_next = (lvl_reg < lc_reg - 2'd1) ? S_LEVEL : S_F_INIT;
            S_F_INIT:   state_next = S_F_RD;
            S_F_RD:     state_next = S_F_LVL;
            S_F_LVL:    state_next = S_F_NODE;
            S_F_NODE:   state_next = S_F_SWEEP;
            S_F_SWEEP:  if (slot_last) state_next = S_F_DRAIN;
            S_F_DRAIN:  state_next = S_F_ADV;
            S_F_ADV: begin
                if (o_inc == end_reg && (lvl_reg == 2'd0 || nc_reg == end_reg)) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_F_RD;
                end
            end
            S_DONE:     if (!pend_reg || out_room) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        logic [63:0] acc_new;
        logic        nonempty, e_new, f_new;
        occ_state_t  st_new;

        nc_next      = nc_reg;
        mc_next      = mc_reg;
        cnt_next     = cnt_reg;
        lvl_next     = lvl_reg;
        p_v_next     = 1'b0;
        p_slot_next  = p_slot_reg;
        p_idx_next   = p_idx_reg;
        acc_next     = acc_reg;
        empty_next   = empty_reg;
        full_next    = full_reg;
        o_next       = o_reg;
        end_next     = end_reg;
        cd_next      = cd_reg;
        cm_next      = cm_reg;
        leaf_next    = leaf_reg;
        root_next    = root_reg;
        pend_set     = 1'b0;
        pend_op_next = pend_op_reg;
        pend_ok_next = pend_ok_reg;
        vox_we       = 1'b0;
        vox_ra       = '0;
        brick_we     = 1'b0;
        mid_we       = 1'b0;
        lvl_ra       = '0;
        lvl_wd       = '0;
        dense_we     = 1'b0;
        dense_wa     = nc_reg;
        dense_wd     = p_idx_reg;
        node_we      = 1'b0;
        nlink_wd     = '0;
        rd_node      = 1'b0;
        rd_mat       = 1'b0;
        leaf_we      = 1'b0;
        leaf_wd      = vox_q[15:0];
        acc_new      = '0;
        nonempty     = 1'b0;
        e_new        = 1'b0;
        f_new        = 1'b0;
        st_new       = ST_EMPTY;

        // stage after a memory read: consume the data of the previous issue
        case (state_reg)
            S_BRICK, S_BRICK_DR: begin
                if (p_v_reg) begin
                    acc_new  = {vox_q[16], acc_reg[63:1]};
                    acc_next = acc_new;
                    if (&p_slot_reg) begin
                        brick_we = 1'b1;
                        lvl_wd   = {mask_state(acc_new), acc_new};
                    end
                end
            end
            S_LEVEL, S_LEVEL_DR: begin
                if (p_v_reg) begin
                    nonempty   = (cs != ST_EMPTY);
                    acc_new    = {nonempty, acc_reg[63:1]};
                    e_new      = ((p_slot_reg == 6'd0) || empty_reg) && !nonempty;
                    f_new      = ((p_slot_reg == 6'd0) || full_reg) && (cs == ST_FULL);
                    acc_next   = acc_new;
                    empty_next = e_new;
                    full_next  = f_new;
                    if (&p_slot_reg) begin
                        st_new = e_new ? ST_EMPTY : (f_new ? ST_FULL : ST_MIXED);
                        lvl_wd = {st_new, (st_new == ST_FULL) ? {64{1'b1}} : acc_new};
                        if (lvl_reg == 2'd1) begin
                            mid_we = 1'b1;
                        end else begin
                            root_next = lvl_wd;
                        end
                    end
                end
            end
            S_F_SWEEP, S_F_DRAIN: begin
                if (p_v_reg) begin
                    if (leaf_reg) begin
                        if (!mc_reg[18]) begin
                            leaf_we = 1'b1;
                            mc_next = mc_reg + 19'd1;
                        end
                    end else if (cs != ST_EMPTY && nc_reg < 13'(NODE_DEPTH)) begin
                        dense_we = 1'b1;
                        nc_next  = nc_reg + 13'd1;
                    end
                end
            end
            default: begin
            end
        endcase

        // issue side of each step
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (in_op)
                        OP_WRITE: vox_we = 1'b1;
                        OP_BUILD: begin
                            if (lc_reg != 2'd0) begin
                                nc_next  = '0;
                                mc_next  = '0;
                                cnt_next = '0;
                            end
                        end
                        OP_READ_NODE: begin
                            rd_node      = 1'b1;
                            pend_set     = 1'b1;
                            pend_op_next = OP_READ_NODE;
                            pend_ok_next = {5'd0, nc_reg} > in_ri;
                        end
                        OP_READ_MAT: begin
                            rd_mat       = 1'b1;
                            pend_set     = 1'b1;
                            pend_op_next = OP_READ_MAT;
                            pend_ok_next = {1'b0, in_ri} < mc_reg;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_BRICK: begin
                vox_ra      = vox_addr(cnt_reg[17:6], cnt_reg[5:0]);
                p_v_next    = 1'b1;
                p_slot_next = cnt_reg[5:0];
                p_idx_next  = cnt_reg[17:6];
                cnt_next    = cnt_reg + 18'd1;
            end
            S_BRICK_DR: begin
                lvl_next = 2'd1;
                cnt_next = '0;
            end
            S_LEVEL: begin
                lvl_ra      = child_idx(lvl_reg, cnt_reg[11:6], cnt_reg[5:0]);
                p_v_next    = 1'b1;
                p_slot_next = cnt_reg[5:0];
                p_idx_next  = {6'd0, cnt_reg[11:6]};
                cnt_next    = cnt_reg + 18'd1;
            end
            S_LEVEL_DR: begin
                lvl_next = lvl_reg + 2'd1;
                cnt_next = '0;
            end
            S_F_INIT: begin
                lvl_next = lc_reg - 2'd1;
                dense_we = 1'b1;
                dense_wa = '0;
                dense_wd = '0;
                nc_next  = 13'd1;
                o_next   = '0;
                end_next = 13'd1;
            end
            S_F_LVL: begin
                lvl_ra  = dense_q;
                cd_next = dense_q;
            end
            S_F_NODE: begin
                cm_next   = lvl_q[63:0];
                leaf_next = leaf_c;
                node_we   = 1'b1;
                nlink_wd  = leaf_c ? (LEAF_BIT | {13'd0, mc_reg}) : {19'd0, nc_reg};
                cnt_next  = '0;
            end
            S_F_SWEEP: begin
                p_v_next   = cm_reg[cnt_reg[5:0]];
                p_idx_next = child_idx(lvl_reg, cd_reg[5:0], cnt_reg[5:0]);
                vox_ra     = (lvl_reg == 2'd0) ? vox_addr(cd_reg, cnt_reg[5:0])
                                               : corner(lvl_reg, cd_reg[5:0]);
                lvl_ra     = child_idx(lvl_reg, cd_reg[5:0], cnt_reg[5:0]);
                cnt_next   = cnt_reg + 18'd1;
            end
            S_F_ADV: begin
                o_next = o_inc;
                if (o_inc == end_reg && lvl_reg != 2'd0 && nc_reg != end_reg) begin
                    lvl_next = lvl_reg - 2'd1;
                    end_next = nc_reg;
                end
            end
            S_DONE: begin
                if (!pend_reg || out_room) begin
                    pend_set     = 1'b1;
                    pend_op_next = OP_BUILD;
                    pend_ok_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign pend_next = (pend_reg && !move) || pend_set;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            lc_reg    <= 2'd3;
            nc_reg    <= '0;
            mc_reg    <= '0;
            root_reg  <= '0;
            pend_reg  <= 1'b0;
            p_v_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                lc_reg <= cfg_data;
            end
            nc_reg    <= nc_next;
            mc_reg    <= mc_next;
            root_reg  <= root_next;
            pend_reg  <= pend_next;
            p_v_reg   <= p_v_next;
        end
    end

    // sequencer payload registers
    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        lvl_reg     <= lvl_next;
        p_slot_reg  <= p_slot_next;
        p_idx_reg   <= p_idx_next;
        acc_reg     <= acc_next;
        empty_reg   <= empty_next;
        full_reg    <= full_next;
        o_reg       <= o_next;
        end_reg     <= end_next;
        cd_reg      <= cd_next;
        cm_reg      <= cm_next;
        leaf_reg    <= leaf_next;
        pend_op_reg <= pend_op_next;
        pend_ok_reg <= pend_ok_next;
    end

    // voxel store: occupancy and material
    always_ff @(posedge aclk) begin
        if (vox_we) begin
            vox_mem[{in_z, in_y, in_x}] <= {in_occ, in_mat};
        end
        vox_q <= vox_mem[vox_ra];
    end

    // brick and middle level stores
    always_ff @(posedge aclk) begin
        if (brick_we) begin
            brick_mem[p_idx_reg] <= lvl_wd;
        end
        brick_q <= brick_mem[lvl_ra];
    end

    always_ff @(posedge aclk) begin
        if (mid_we) begin
            mid_mem[p_idx_reg[MID_AW-1:0]] <= lvl_wd;
        end
        mid_q <= mid_mem[lvl_ra[MID_AW-1:0]];
    end

    // breadth-first queue: dense index of each emitted node
    always_ff @(posedge aclk) begin
        if (dense_we) begin
            dense_mem[dense_wa] <= dense_wd;
        end
        dense_q <= dense_mem[o_reg];
    end

    // node table
    always_ff @(posedge aclk) begin
        if (node_we) begin
            nmask_mem[o_reg] <= lvl_q[63:0];
            nlink_mem[o_reg] <= nlink_wd;
        end
        if (rd_node) begin
            nmask_q <= nmask_mem[in_ri[NODE_AW-1:0]];
            nlink_q <= nlink_mem[in_ri[NODE_AW-1:0]];
        end
    end

    // leaf material list
    always_ff @(posedge aclk) begin
        if (leaf_we) begin
            leaf_mem[mc_reg[VOX_AW-1:0]] <= leaf_wd;
        end
        if (rd_mat) begin
            lmat_q <= leaf_mem[in_ri];
        end
    end

    // result beat assembly
    always_comb begin
        res.node_mask      = (pend_op_reg == OP_READ_NODE && pend_ok_reg) ? nmask_q : '0;
        res.child_link     = (pend_op_reg == OP_READ_NODE && pend_ok_reg) ? nlink_q : '0;
        res.leaf_material  = (pend_op_reg == OP_READ_MAT && pend_ok_reg) ? lmat_q : '0;
        res.node_total     = nc_reg;
        res.material_total = mc_reg;
        res.index_valid    = pend_ok_reg;
    end

    svtb_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (move),
        .res      (res),
        .room     (out_room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // input only taken while the sequencer rests
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE)
        else $error("input accepted while build in progress");

    // node count never passes the table depth
    a_node_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nc_reg <= 13'(NODE_DEPTH))
        else $error("node counter beyond table depth");

    // material count never passes the list depth
    a_mat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        mc_reg <= 19'(VOX_DEPTH))
        else $error("material counter beyond list depth");

    // no read result left waiting during the brick pass
    a_build_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_BRICK |-> !pend_reg)
        else $error("pending result during build");

endmodule

// ----- tb/sv/sparse_voxel_tree_builder_top_tb.sv -----
`timescale 1ns/1ps
module sparse_voxel_tree_builder_top_tb;
    import svtb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID      = 64;
    localparam int DRAIN_CYC = 20;
    localparam int IDLE_LIMIT = 2000000;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [55:0]   s_tdata = '0;
    logic [1:0]    s_tuser = OP_WRITE;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [143:0]  m_tdata;
    logic [0:0]    m_tuser;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_data = '0;

    sparse_voxel_tree_builder_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // shadow copy of the block state
    bit          occ_mem [VOX_DEPTH];
    logic [15:0] mat_mem [VOX_DEPTH];
    logic [63:0] brick_m [BRICK_DEPTH];
    occ_state_t  brick_s [BRICK_DEPTH];
    logic [63:0] mid_m [MID_DEPTH];
    occ_state_t  mid_s [MID_DEPTH];
    logic [63:0] root_m = '0;
    occ_state_t  root_s = ST_EMPTY;
    logic [63:0] node_mask_tab [NODE_DEPTH];
    logic [31:0] node_link_tab [NODE_DEPTH];
    logic [15:0] leaf_list [VOX_DEPTH];
    int          node_cnt = 0;
    int          mat_cnt = 0;
    int          level_cfg = 3;

    result_t     expected_beats [$];
    int          errors = 0;
    bit          quiet = 1'b0;

    function automatic int vidx(int x, int y, int z);
        return (x + GRID * (y + GRID * z)) & (VOX_DEPTH - 1);
    endfunction

    function automatic logic [63:0] lvl_mask(int d, int i);
        if (d == 0) return brick_m[i & (BRICK_DEPTH - 1)];
        if (d == 1) return mid_m[i & (MID_DEPTH - 1)];
        return root_m;
    endfunction

    function automatic occ_state_t lvl_state(int d, int i);
        if (d == 0) return brick_s[i & (BRICK_DEPTH - 1)];
        if (d == 1) return mid_s[i & (MID_DEPTH - 1)];
        return root_s;
    endfunction

    function automatic void lvl_set(int d, int i, logic [63:0] m, occ_state_t s);
        if (d == 0) begin
            brick_m[i & (BRICK_DEPTH - 1)] = m;
            brick_s[i & (BRICK_DEPTH - 1)] = s;
        end else if (d == 1) begin
            mid_m[i & (MID_DEPTH - 1)] = m;
            mid_s[i & (MID_DEPTH - 1)] = s;
        end else begin
            root_m = m;
            root_s = s;
        end
    endfunction

    function automatic void push_leaf_mat(logic [15:0] m);
        if (mat_cnt < VOX_DEPTH) begin
            leaf_list[mat_cnt] = m;
            mat_cnt++;
        end
    endfunction

    // brick masks, parent levels, then breadth-first flattening
    function automatic void tree_build();
        int ax [3];
        int d, i, a, ca, slot, px, py, pz, cx, cy, cz, ci, k, sc, dense, o, n_next;
        logic [63:0] m, occm;
        bit emp, full;
        occ_state_t s, cs;
        int cur_d [$], cur_o [$], nxt_d [$], nxt_o [$];
        if (level_cfg == 0 || level_cfg > MAX_LEVELS) return;
        node_cnt = 0;
        mat_cnt = 0;
        ax[0] = GRID / 4;
        for (d = 0; d < level_cfg; d++) begin
            if (d > 0) ax[d] = ax[d-1] / 4;
            if (ax[d] == 0) return;
        end
        a = ax[0];
        for (i = 0; i < a * a * a; i++) begin
            px = i % a; py = (i / a) % a; pz = i / (a * a);
            m = '0;
            for (slot = 0; slot < 64; slot++)
                m[slot] = occ_mem[vidx(px*4 + (slot & 3), py*4 + ((slot >> 2) & 3),
                                       pz*4 + ((slot >> 4) & 3))];
            lvl_set(0, i, m, m == '0 ? ST_EMPTY : (m == '1 ? ST_FULL : ST_MIXED));
        end
        for (d = 1; d < level_cfg; d++) begin
            ca = ax[d-1];
            a = ax[d];
            for (i = 0; i < a * a * a; i++) begin
                px = i % a; py = (i / a) % a; pz = i / (a * a);
                emp = 1'b1; full = 1'b1; occm = '0;
                for (slot = 0; slot < 64; slot++) begin
                    cx = px*4 + (slot & 3);
                    cy = py*4 + ((slot >> 2) & 3);
                    cz = pz*4 + ((slot >> 4) & 3);
                    cs = lvl_state(d - 1, cx + ca * (cy + ca * cz));
                    if (cs != ST_EMPTY) begin
                        emp = 1'b0;
                        occm[slot] = 1'b1;
                    end
                    if (cs != ST_FULL) full = 1'b0;
                end
                s = emp ? ST_EMPTY : (full ? ST_FULL : ST_MIXED);
                lvl_set(d, i, s == ST_FULL ? '1 : occm, s);
            end
        end
        d = level_cfg - 1;
        node_mask_tab[0] = lvl_mask(d, 0);
        node_link_tab[0] = '0;
        node_cnt = 1;
        cur_d.push_back(0);
        cur_o.push_back(0);
        forever begin
            a = ax[d];
            nxt_d.delete();
            nxt_o.delete();
            n_next = 0;
            for (k = 0; k < cur_d.size(); k++) begin
                dense = cur_d[k];
                o = cur_o[k];
                m = lvl_mask(d, dense);
                s = lvl_state(d, dense);
                if (o >= NODE_DEPTH) continue;
                node_mask_tab[o] = m;
                px = dense % a; py = (dense / a) % a; pz = dense / (a * a);
                if (d == 0 || s == ST_FULL) begin
                    // leaf: materials per set bit, a full upper node repeats its corner
                    sc = GRID / a;
                    node_link_tab[o] = {1'b1, 31'(mat_cnt)};
                    for (slot = 0; slot < 64; slot++) begin
                        if (!m[slot]) continue;
                        if (d == 0)
                            push_leaf_mat(mat_mem[vidx(px*4 + (slot & 3),
                                py*4 + ((slot >> 2) & 3), pz*4 + ((slot >> 4) & 3))]);
                        else
                            push_leaf_mat(mat_mem[vidx(px*sc, py*sc, pz*sc)]);
                    end
                    continue;
                end
                node_link_tab[o] = 32'(node_cnt);
                ca = ax[d-1];
                for (slot = 0; slot < 64; slot++) begin
                    if (!m[slot]) continue;
                    cx = px*4 + (slot & 3);
                    cy = py*4 + ((slot >> 2) & 3);
                    cz = pz*4 + ((slot >> 4) & 3);
                    ci = cx + ca * (cy + ca * cz);
                    if (lvl_state(d - 1, ci) == ST_EMPTY) continue;
                    if (node_cnt >= NODE_DEPTH || n_next >= BRICK_DEPTH) continue;
                    node_mask_tab[node_cnt] = lvl_mask(d - 1, ci);
                    node_link_tab[node_cnt] = '0;
                    nxt_d.push_back(ci);
                    nxt_o.push_back(node_cnt);
                    n_next++;
                    node_cnt++;
                end
            end
            if (d == 0) break;
            cur_d = nxt_d;
            cur_o = nxt_o;
            d--;
        end
    endfunction

    // expected answer for one accepted beat
    function automatic bit predict_answer(op_t op, logic [55:0] data, output result_t r);
        int x, y, z, ri;
        x = data[5:0]; y = data[11:6]; z = data[17:12]; ri = data[52:35];
        r = '0;
        if (op == OP_WRITE) begin
            occ_mem[vidx(x, y, z)] = data[18];
            mat_mem[vidx(x, y, z)] = data[34:19];
            return 1'b0;
        end
        if (op == OP_BUILD) tree_build();
        r.node_total = 13'(node_cnt);
        r.material_total = 19'(mat_cnt);
        if (op == OP_READ_NODE && ri < node_cnt && ri < NODE_DEPTH) begin
            r.node_mask = node_mask_tab[ri];
            r.child_link = node_link_tab[ri];
            r.index_valid = 1'b1;
        end else if (op == OP_READ_MAT && ri < mat_cnt) begin
            r.leaf_material = leaf_list[ri];
            r.index_valid = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic logic [55:0] pack_in(int x, int y, int z, bit o, int mat, int ri);
        return {3'b0, 18'(ri), 16'(mat), o, 6'(z), 6'(y), 6'(x)};
    endfunction

    // send one input beat; a typed expectation overrides the prediction
    task automatic send_beat(op_t op, logic [55:0] data, bit typed, result_t typed_res);
        result_t r;
        bit has;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 15) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        has = predict_answer(op, data, r);
        if (has) expected_beats.push_back(typed ? typed_res : r);
    endtask

    task automatic send_pred(op_t op, logic [55:0] data);
        send_beat(op, data, 1'b0, '0);
    endtask

    task automatic stop_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic write_level(int v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= 2'(v);
        do @(posedge aclk); while (!cfg_ready);
        level_cfg = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // occupancy pattern for the initial grid fill
    function automatic bit fill_occ(int x, int y, int z);
        int bx, by, bz, h;
        bx = x >> 2; by = y >> 2; bz = z >> 2;
        if (x >= 16 && x < 32 && y < 16 && z < 16) return 1'b1;
        if (x < 16 && y < 16 && z < 16) begin
            h = (bx * 7 + by * 3 + bz * 5) % 4;
            if (h == 0) return 1'b0;
            if (h == 1) return 1'b1;
            return bit'($urandom_range(0, 1));
        end
        if ((bx + 16 * (by + 16 * bz)) % 97 == 5) return bit'($urandom_range(0, 1));
        return 1'b0;
    endfunction

    // mix of voxel rewrites and table reads, mostly inside the counts
    task automatic random_mix(int n, int wr_pct);
        int r, ri;
        op_t op;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < wr_pct) begin
                send_pred(OP_WRITE, pack_in($urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 63), $urandom_range(0, 1), $urandom_range(0, 65535),
                    $urandom_range(0, 262143)));
            end else begin
                op = (r % 2) ? OP_READ_NODE : OP_READ_MAT;
                if ($urandom_range(0, 9) == 0)
                    ri = $urandom_range(0, 262143);
                else if (op == OP_READ_NODE)
                    ri = $urandom_range(0, node_cnt + 1);
                else
                    ri = $urandom_range(0, mat_cnt + 1);
                send_pred(op, pack_in($urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 63), $urandom_range(0, 1), $urandom_range(0, 65535),
                    ri));
            end
        end
    endtask

    // directed rows, run with the level register at zero
    typedef struct {
        op_t         op;
        logic [55:0] data;
        bit          typed;
        result_t     res;
    } stim_row_t;

    stim_row_t dir_rows [] = '{
        '{OP_READ_NODE, 56'(0), 1'b1, '0},
        '{OP_READ_NODE, {3'b0, 18'h3FFFF, 35'h0}, 1'b1, '0},
        '{OP_READ_MAT, 56'(0), 1'b1, '0},
        '{OP_READ_MAT, {3'b0, 18'h3FFFF, 35'h0}, 1'b1, '0},
        '{OP_WRITE, {3'b0, 18'h3FFFF, 16'hFFFF, 1'b1, 6'd63, 6'd63, 6'd63}, 1'b0, '0},
        '{OP_WRITE, 56'(0), 1'b0, '0},
        '{OP_BUILD, 56'(0), 1'b1, '0},
        '{OP_READ_NODE, 56'(0), 1'b1, '0},
        '{OP_READ_MAT, 56'(0), 1'b1, '0}
    };

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // result beat check
    always @(posedge aclk) begin
        result_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata[63:0], '0);
            end else begin
                w = expected_beats.pop_front();
                if (m_tdata[63:0] !== w.node_mask)
                    report_mismatch("node_mask", m_tdata[63:0], w.node_mask);
                if (m_tdata[95:64] !== w.child_link)
                    report_mismatch("child_link", m_tdata[95:64], w.child_link);
                if (m_tdata[111:96] !== w.leaf_material)
                    report_mismatch("leaf_material", m_tdata[111:96], w.leaf_material);
                if (m_tdata[124:112] !== w.node_total)
                    report_mismatch("node_total", m_tdata[124:112], w.node_total);
                if (m_tdata[143:125] !== w.material_total)
                    report_mismatch("material_total", m_tdata[143:125], w.material_total);
                if (m_tuser[0] !== w.index_valid)
                    report_mismatch("index_valid", m_tuser[0], w.index_valid);
            end
        end
    end

    // receiver stalls in short bursts
    int stall_left = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any accepted beat
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("sparse_voxel_tree_builder_top verification failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part: reset state, field extremes, ignored build
        write_level(0);
        foreach (dir_rows[i]) send_beat(dir_rows[i].op, dir_rows[i].data, dir_rows[i].typed,
                                        dir_rows[i].res);
        stop_input();
        wait_drained();
        write_level(3);

        // fill every voxel so that builds read defined data
        for (int z = 0; z < GRID; z++)
            for (int y = 0; y < GRID; y++)
                for (int x = 0; x < GRID; x++)
                    send_pred(OP_WRITE, pack_in(x, y, z, fill_occ(x, y, z),
                        $urandom_range(0, 65535), $urandom_range(0, 262143)));

        // full three-level build, then reads of the edges and a random mix
        send_pred(OP_BUILD, 56'(0));
        send_pred(OP_READ_NODE, 56'(0));
        send_pred(OP_READ_NODE, pack_in(0, 0, 0, 0, 0, node_cnt - 1));
        send_pred(OP_READ_NODE, pack_in(0, 0, 0, 0, 0, node_cnt));
        send_pred(OP_READ_MAT, pack_in(0, 0, 0, 0, 0, mat_cnt - 1));
        send_pred(OP_READ_MAT, pack_in(0, 0, 0, 0, 0, mat_cnt));
        random_mix(300, 25);
        stop_input();
        wait_drained();

        // single-level build: root is brick zero
        write_level(1);
        send_pred(OP_BUILD, 56'(0));
        random_mix(200, 20);
        stop_input();
        wait_drained();

        // two-level build, last stretch without idling
        write_level(2);
        send_pred(OP_BUILD, 56'(0));
        random_mix(150, 20);
        quiet = 1'b1;
        random_mix(150, 20);
        stop_input();
        wait_drained();

        if (errors == 0)
            $display("sparse_voxel_tree_builder_top verification clean");
        else
            $display("sparse_voxel_tree_builder_top verification failed");
        $finish;
    end

endmodule
